@@ rtl/jsp_pkg.sv @@
// ----------------------------------------------------------------------------
// jsp_pkg: shared types, constants and microcode for the Julia pixel
// Holds the item payload structs, fixed-point widths, register indexes and
// the control store that sequences the escape-time datapath.
// ----------------------------------------------------------------------------
package jsp_pkg;

    // Default grid side (start points per row and per column)
    localparam int GRID_SIDE_DEF = 5;

    // Fixed-point format: 28 fraction bits
    localparam int    FRAC_BITS = 28;
    localparam longint ONE_FIX  = 64'sd1 <<< FRAC_BITS;

    // z register, multiplier operand and product widths
    localparam int Z_W    = 34;
    localparam int PT_W   = 30;
    localparam int PROD_W = 2 * PT_W;

    // Escape bounds: |coordinate| >= 2 and |z|^2 >= 4
    localparam logic signed [Z_W-1:0]  Z_TWO    = Z_W'(64'sd2 <<< FRAC_BITS);
    localparam logic signed [Z_W-1:0]  Z_NTWO   = -Z_TWO;
    localparam logic signed [PROD_W:0] MAG_FOUR = (PROD_W + 1)'(64'sd4 <<< (2 * FRAC_BITS));

    // Shared divider: 16-bit dividend, 9-bit divisor, 8 quotient bits
    localparam int DIVN_W = 16;
    localparam int DEN_W  = 9;
    localparam int DCNT_W = 3;
    localparam logic [DCNT_W-1:0] DIV_LAST = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 1'd1;
    localparam logic [7:0] MAX_ITER_RST = 8'd30;
    localparam logic [3:0] GAIN_RST     = 4'd2;

    // Item payloads
    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } t_in_item;

    typedef struct packed {
        logic [7:0] grey;
        logic       clipped;
    } t_out_item;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        UOP_NOP   = 4'd0,
        UOP_START = 4'd1,
        UOP_PINIT = 4'd2,
        UOP_MUL   = 4'd3,
        UOP_UPD   = 4'd4,
        UOP_GREY  = 4'd5,
        UOP_DIV   = 4'd6,
        UOP_ACC   = 4'd7,
        UOP_MEAN  = 4'd8,
        UOP_OUT   = 4'd9
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_ALWAYS      = 3'd1,
        COND_NOT_START   = 3'd2,
        COND_EXIT        = 3'd3,
        COND_NOT_ESC     = 3'd4,
        COND_DIV_BUSY    = 3'd5,
        COND_MORE_POINTS = 3'd6
    } t_cond;

    // Program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] S_PINIT = 4'd1;
    localparam logic [STEP_W-1:0] S_MUL   = 4'd2;
    localparam logic [STEP_W-1:0] S_UPD   = 4'd3;
    localparam logic [STEP_W-1:0] S_GREY  = 4'd4;
    localparam logic [STEP_W-1:0] S_GDIV  = 4'd5;
    localparam logic [STEP_W-1:0] S_ACC   = 4'd6;
    localparam logic [STEP_W-1:0] S_MEAN  = 4'd7;
    localparam logic [STEP_W-1:0] S_MDIV  = 4'd8;
    localparam logic [STEP_W-1:0] S_OUT   = 4'd9;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control store: jump to target when the condition holds, else step on
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword uw;
        case (step)
            S_IDLE:  uw = '{UOP_START, COND_NOT_START,   S_IDLE};
            S_PINIT: uw = '{UOP_PINIT, COND_NEVER,       S_IDLE};
            S_MUL:   uw = '{UOP_MUL,   COND_EXIT,        S_GREY};
            S_UPD:   uw = '{UOP_UPD,   COND_NOT_ESC,     S_MUL};
            S_GREY:  uw = '{UOP_GREY,  COND_NEVER,       S_IDLE};
            S_GDIV:  uw = '{UOP_DIV,   COND_DIV_BUSY,    S_GDIV};
            S_ACC:   uw = '{UOP_ACC,   COND_MORE_POINTS, S_PINIT};
            S_MEAN:  uw = '{UOP_MEAN,  COND_NEVER,       S_IDLE};
            S_MDIV:  uw = '{UOP_DIV,   COND_DIV_BUSY,    S_MDIV};
            S_OUT:   uw = '{UOP_OUT,   COND_ALWAYS,      S_IDLE};
            default: uw = '{UOP_NOP,   COND_ALWAYS,      S_IDLE};
        endcase
        return uw;
    endfunction

endpackage

@@ rtl/julia_supersampled_pixel.sv @@
// ----------------------------------------------------------------------------
// julia_supersampled_pixel: one supersampled grey pixel of a Julia set
// Iterates z = z*z + c over a GRID_SIDE x GRID_SIDE grid of start points,
// averages the escape-time greys and applies a saturating gain.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item (c_re, c_im) and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays high until
//   the result is on o_item, and drops in that cycle. One item is in flight.
//   The result appears on o_item for exactly one cycle with o_valid high; the
//   receiver has no way to stall it and must take it then. Registers
//   max_iter (index 0) and gain (index 1) are written through i_cfg_we /
//   i_cfg_idx / i_cfg_wdata; only the user ensures the block is then idle.
// Sequence:
//   Each grid point loads z, then alternates a complex multiply (three
//   30x30 products in parallel) with an escape test and z update, and
//   forms its grey with a radix-2 divide. After the last point come the
//   mean divide, gain and output strobe. A new item can be taken in the
//   strobe cycle.
// Reset:
//   Synchronous, active low: returns to idle, max_iter = 30, gain = 2.
// ----------------------------------------------------------------------------
module julia_supersampled_pixel #(
    parameter int GRID_SIDE = jsp_pkg::GRID_SIDE_DEF   // 1 .. 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  jsp_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    output jsp_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_we,
    input  logic [jsp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [jsp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import jsp_pkg::*;

    // Grid geometry, all worked out at elaboration
    localparam int     IDX_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int     G2    = 2 * GRID_SIDE;
    localparam int     REM_W = $clog2(G2) + 1;
    localparam longint G2L   = longint'(G2);

    // Real start: floor((3*(2i-G)*ONE + G) / 2G), stepped by 6*ONE / 2G
    localparam longint RE_NUM0 = -longint'(3 * GRID_SIDE) * ONE_FIX + longint'(GRID_SIDE);
    localparam longint RE_Q0   = RE_NUM0 / G2L - (((RE_NUM0 % G2L) != 0) ? 64'sd1 : 64'sd0);
    localparam longint RE_R0   = RE_NUM0 - RE_Q0 * G2L;
    localparam longint RE_SQ   = (6 * ONE_FIX) / G2L;
    localparam longint RE_SR   = (6 * ONE_FIX) % G2L;

    // Imaginary start: floor((2*(2j-G)*ONE + G) / 2G), stepped by 4*ONE / 2G
    localparam longint IM_NUM0 = -longint'(2 * GRID_SIDE) * ONE_FIX + longint'(GRID_SIDE);
    localparam longint IM_Q0   = IM_NUM0 / G2L - (((IM_NUM0 % G2L) != 0) ? 64'sd1 : 64'sd0);
    localparam longint IM_R0   = IM_NUM0 - IM_Q0 * G2L;
    localparam longint IM_SQ   = (4 * ONE_FIX) / G2L;
    localparam longint IM_SR   = (4 * ONE_FIX) % G2L;

    localparam logic [DEN_W-1:0] MEAN_DEN = DEN_W'(GRID_SIDE * GRID_SIDE);

    // Sequencer and configuration
    logic [STEP_W-1:0] r_step, n_step;
    logic [7:0]        r_max_iter;
    logic [3:0]        r_gain;
    logic              r_valid;
    t_out_item         r_out;
    t_uword            w_uw;
    logic              w_jump;

    // Datapath registers
    logic signed [31:0]     r_cre, r_cim;
    logic signed [PT_W-1:0] r_re0, r_im0;
    logic [REM_W-1:0]       r_re_rem, r_im_rem;
    logic [IDX_W-1:0]       r_i, r_j;
    logic signed [Z_W-1:0]  r_zr, r_zi;
    logic [7:0]             r_count;
    logic signed [PROD_W-1:0] r_rr, r_ii, r_ri;
    logic [DIVN_W-1:0]      r_sum;
    logic [7:0]             r_drem, r_dlo;
    logic [DEN_W-1:0]       r_dden;
    logic [DCNT_W-1:0]      r_dcnt;

    // Combinational datapath
    logic signed [PT_W-1:0]   w_mzr, w_mzi;
    logic signed [PROD_W-1:0] w_rr, w_ii, w_ri, w_diff;
    logic signed [PROD_W:0]   w_mag;
    logic signed [31:0]       w_re_sh, w_im_sh;
    logic                     w_exit, w_esc, w_limit;
    logic                     w_i_last, w_j_last;
    logic [REM_W-1:0]         w_re_rsum, w_im_rsum;
    logic                     w_re_cy, w_im_cy;
    logic signed [PT_W-1:0]   w_re0_nx, w_im0_nx;
    logic [DIVN_W-1:0]        w_gnum;
    logic [DEN_W-1:0]         w_gden;
    logic [DEN_W-1:0]         w_dtry;
    logic                     w_dge;
    logic [11:0]              w_scaled;

    assign w_uw = ucode(r_step);
    assign busy = (r_step != S_IDLE);

    // Complex square: three products in parallel
    assign w_mzr = r_zr[PT_W-1:0];
    assign w_mzi = r_zi[PT_W-1:0];
    assign w_rr  = w_mzr * w_mzr;
    assign w_ii  = w_mzi * w_mzi;
    assign w_ri  = w_mzr * w_mzi;

    // Escape tests: coordinate bound, iteration limit, magnitude
    assign w_exit = (r_count >= r_max_iter)
                 || (r_zr >= Z_TWO) || (r_zr <= Z_NTWO)
                 || (r_zi >= Z_TWO) || (r_zi <= Z_NTWO);
    assign w_mag  = {r_rr[PROD_W-1], r_rr} + {r_ii[PROD_W-1], r_ii};
    assign w_esc  = (w_mag >= MAG_FOUR);

    // Floor back to 28 fraction bits; 2*re*im takes one bit less of shift
    assign w_diff  = r_rr - r_ii;
    assign w_re_sh = w_diff[FRAC_BITS+31:FRAC_BITS];
    assign w_im_sh = r_ri[FRAC_BITS+30:FRAC_BITS-1];

    // Grid walk
    assign w_i_last = (r_i == IDX_W'(GRID_SIDE - 1));
    assign w_j_last = (r_j == IDX_W'(GRID_SIDE - 1));
    assign w_re_rsum = r_re_rem + REM_W'(RE_SR);
    assign w_im_rsum = r_im_rem + REM_W'(IM_SR);
    assign w_re_cy   = (w_re_rsum >= REM_W'(G2));
    assign w_im_cy   = (w_im_rsum >= REM_W'(G2));
    assign w_re0_nx  = r_re0 + PT_W'(RE_SQ) + PT_W'(w_re_cy);
    assign w_im0_nx  = r_im0 + PT_W'(IM_SQ) + PT_W'(w_im_cy);

    // Point grey dividend count*255 over max_iter; a limit point divides 0 by 1
    assign w_limit = (r_count == r_max_iter);
    assign w_gnum  = w_limit ? '0 : ({r_count, 8'd0} - {8'd0, r_count});
    assign w_gden  = w_limit ? DEN_W'(1) : {1'b0, r_max_iter};

    // Restoring divider step: shift in one dividend bit, try subtract
    assign w_dtry = {r_drem, r_dlo[7]};
    assign w_dge  = (w_dtry >= r_dden);

    assign w_scaled = 12'(r_dlo) * 12'(r_gain);

    // Evaluate jump condition
    always_comb begin
        case (w_uw.cond)
            COND_NEVER:       w_jump = 1'b0;
            COND_ALWAYS:      w_jump = 1'b1;
            COND_NOT_START:   w_jump = !start;
            COND_EXIT:        w_jump = w_exit;
            COND_NOT_ESC:     w_jump = !w_esc;
            COND_DIV_BUSY:    w_jump = (r_dcnt != DIV_LAST);
            COND_MORE_POINTS: w_jump = !(w_i_last && w_j_last);
            default:          w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_uw.target : r_step + STEP_W'(1);
    end

    // Advance step counter, hold configuration, pulse result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= S_IDLE;
            r_max_iter <= MAX_ITER_RST;
            r_gain     <= GAIN_RST;
            r_valid    <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= (w_uw.op == UOP_OUT);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_ITER: r_max_iter <= i_cfg_wdata;
                    CFG_GAIN:     r_gain     <= i_cfg_wdata[3:0];
                    default:      ;
                endcase
            end
        end
    end

    // Datapath, driven by the current control word
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            UOP_START: begin
                if (start) begin
                    r_cre    <= i_item.c_re;
                    r_cim    <= i_item.c_im;
                    r_i      <= '0;
                    r_j      <= '0;
                    r_re0    <= PT_W'(RE_Q0);
                    r_re_rem <= REM_W'(RE_R0);
                    r_im0    <= PT_W'(IM_Q0);
                    r_im_rem <= REM_W'(IM_R0);
                    r_sum    <= '0;
                end
            end
            UOP_PINIT: begin
                r_zr    <= {{(Z_W-PT_W){r_re0[PT_W-1]}}, r_re0};
                r_zi    <= {{(Z_W-PT_W){r_im0[PT_W-1]}}, r_im0};
                r_count <= '0;
            end
            UOP_MUL: begin
                r_rr <= w_rr;
                r_ii <= w_ii;
                r_ri <= w_ri;
            end
            UOP_UPD: begin
                // drop the update once the point has escaped
                if (!w_esc) begin
                    r_zr    <= {{2{w_re_sh[31]}}, w_re_sh} + {{2{r_cre[31]}}, r_cre};
                    r_zi    <= {{2{w_im_sh[31]}}, w_im_sh} + {{2{r_cim[31]}}, r_cim};
                    r_count <= r_count + 8'd1;
                end
            end
            UOP_GREY: begin
                r_drem <= w_gnum[15:8];
                r_dlo  <= w_gnum[7:0];
                r_dden <= w_gden;
                r_dcnt <= '0;
            end
            UOP_MEAN: begin
                r_drem <= r_sum[15:8];
                r_dlo  <= r_sum[7:0];
                r_dden <= MEAN_DEN;
                r_dcnt <= '0;
            end
            UOP_DIV: begin
                r_drem <= w_dge ? 8'(w_dtry - r_dden) : w_dtry[7:0];
                r_dlo  <= {r_dlo[6:0], w_dge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            UOP_ACC: begin
                r_sum <= r_sum + DIVN_W'(r_dlo);
                if (w_j_last) begin
                    r_j      <= '0;
                    r_im0    <= PT_W'(IM_Q0);
                    r_im_rem <= REM_W'(IM_R0);
                    r_i      <= r_i + IDX_W'(1);
                    r_re0    <= w_re0_nx;
                    r_re_rem <= w_re_cy ? w_re_rsum - REM_W'(G2) : w_re_rsum;
                end else begin
                    r_j      <= r_j + IDX_W'(1);
                    r_im0    <= w_im0_nx;
                    r_im_rem <= w_im_cy ? w_im_rsum - REM_W'(G2) : w_im_rsum;
                end
            end
            UOP_OUT: begin
                r_out.clipped <= (w_scaled > 12'd255);
                r_out.grey    <= (w_scaled > 12'd255) ? 8'd255 : w_scaled[7:0];
            end
            default: ;
        endcase
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for julia_supersampled_pixel
// Drives Julia constants through the start/busy command port and checks
// every pixel against a fixed answer or an in-bench escape-time predictor.
// The run starts with a table of directed cases, then walks phases of random
// constants under different iteration limits and gains.
// ----------------------------------------------------------------------------
module testbench;

    import jsp_pkg::*;

    localparam int GRID     = GRID_SIDE_DEF;
    localparam int N_PHASES = 10;
    localparam int N_DIR    = 22;

    // One directed case: register settings, constant, optional fixed answer
    typedef struct packed {
        logic [7:0]  lim;
        logic [3:0]  gn;
        logic [31:0] cr;
        logic [31:0] ci;
        logic        typed;
        t_out_item   want;
    } t_pixel_case;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_in_item   i_item      = '0;
    logic       o_valid;
    t_out_item  o_item;
    logic       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Bench copy of the register file
    logic [7:0] lim_now  = MAX_ITER_RST;
    logic [3:0] gain_now = GAIN_RST;

    t_out_item pending_pixels [$];
    int        mismatches = 0;

    // Directed cases: huge constants escape after one step, so every point
    // gets floor(255/max_iter); those rows carry their answer directly
    t_pixel_case dir_cases [0:N_DIR-1] = '{
        '{8'd30,  4'd2,  32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{8'd16,  1'b0}},
        '{8'd30,  4'd2,  32'h80000000, 32'h80000000, 1'b1, '{8'd16,  1'b0}},
        '{8'd30,  4'd2,  32'h00000000, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd2,  32'hF4000000, 32'h0199999A, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd2,  32'h20000000, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd2,  32'hE0000000, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd2,  32'h7FFFFFFF, 32'h80000000, 1'b1, '{8'd16,  1'b0}},
        '{8'd30,  4'd2,  32'h00000000, 32'h7FFFFFFF, 1'b1, '{8'd16,  1'b0}},
        '{8'd1,   4'd15, 32'h00000000, 32'h00000000, 1'b1, '{8'd0,   1'b0}},
        '{8'd0,   4'd15, 32'h00000000, 32'h00000000, 1'b1, '{8'd0,   1'b0}},
        '{8'd0,   4'd2,  32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{8'd0,   1'b0}},
        '{8'd2,   4'd2,  32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{8'd254, 1'b0}},
        '{8'd2,   4'd3,  32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{8'd255, 1'b1}},
        '{8'd2,   4'd15, 32'h80000000, 32'h7FFFFFFF, 1'b1, '{8'd255, 1'b1}},
        '{8'd255, 4'd15, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{8'd15,  1'b0}},
        '{8'd255, 4'd15, 32'h00000000, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd255, 4'd0,  32'h00000001, 32'hFFFFFFFF, 1'b1, '{8'd0,   1'b0}},
        '{8'd30,  4'd15, 32'h04000000, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd15, 32'h048F5C29, 32'h0028F5C3, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd1,  32'hFFFFFFFF, 32'h00000001, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd8,  32'hE6666666, 32'h00000000, 1'b0, '{8'd0,   1'b0}},
        '{8'd30,  4'd2,  32'h3FFFFFFF, 32'h00000000, 1'b1, '{8'd16,  1'b0}}
    };

    // Random phases: -1 picks a random setting
    int phase_lim  [0:N_PHASES-1] = '{30, 255, 1,  2, 12,  0, 48, -1, -1, -1};
    int phase_gain [0:N_PHASES-1] = '{ 2,  15, 0, 15,  3,  9,  1, -1, -1, -1};
    int phase_len  [0:N_PHASES-1] = '{150, 12, 60, 80, 120, 20, 40, 90, 90, 90};

    julia_supersampled_pixel #(
        .GRID_SIDE(GRID)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Floor division for the grid start points
    function automatic longint fix_floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Escape-time grey of one supersampled pixel for constant (cr, ci)
    function automatic t_out_item predict_pixel(input logic signed [31:0] cr,
                                                input logic signed [31:0] ci);
        longint      re, im, rr, ii, ri, re0, im0, two, four_sq, cre, cim;
        int unsigned count, sum, mean, scaled;
        int          i, j;
        bit          escaped;
        t_out_item   res;
        two     = longint'(2) <<< FRAC_BITS;
        four_sq = longint'(4) <<< (2 * FRAC_BITS);
        cre     = longint'(cr);
        cim     = longint'(ci);
        sum     = 0;
        for (i = 0; i < GRID; i++) begin
            re0 = fix_floor_div(3 * (2 * i - GRID) * ONE_FIX + GRID, 2 * GRID);
            for (j = 0; j < GRID; j++) begin
                im0     = fix_floor_div(2 * (2 * j - GRID) * ONE_FIX + GRID, 2 * GRID);
                re      = re0;
                im      = im0;
                count   = 0;
                escaped = 1'b0;
                while (count < lim_now && !escaped) begin
                    rr = re * re;
                    ii = im * im;
                    if (re >= two || re <= -two || im >= two || im <= -two) begin
                        escaped = 1'b1;
                    end else if (rr + ii >= four_sq) begin
                        escaped = 1'b1;
                    end else begin
                        ri    = re * im;
                        re    = ((rr - ii) >>> FRAC_BITS) + cre;
                        im    = (ri >>> (FRAC_BITS - 1)) + cim;
                        count = count + 1;
                    end
                end
                // Points that hit the limit are inside and stay black
                if (count != lim_now) begin
                    sum = sum + (count * 255) / lim_now;
                end
            end
        end
        mean   = sum / (GRID * GRID);
        scaled = mean * gain_now;
        res.clipped = (scaled > 255);
        res.grey    = res.clipped ? 8'd255 : scaled[7:0];
        return res;
    endfunction

    // Write one register, one cycle of write enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drain the block, then load both registers
    task automatic set_limits(input logic [7:0] lim, input logic [7:0] gain_byte);
        while (busy || pending_pixels.size() != 0) @(negedge i_clk);
        write_reg(CFG_MAX_ITER, lim);
        write_reg(CFG_GAIN, gain_byte);
        lim_now  = lim;
        gain_now = gain_byte[3:0];
    endtask

    // Hand one item to the block and queue its expected pixel
    task automatic issue_pixel(input logic [31:0] cr, input logic [31:0] ci,
                               input logic typed, input t_out_item typed_want);
        t_out_item want;
        @(negedge i_clk);
        start       <= 1'b1;
        i_item.c_re <= cr;
        i_item.c_im <= ci;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = typed ? typed_want : predict_pixel(cr, ci);
        pending_pixels.push_back(want);
        @(negedge i_clk);
        start  <= 1'b0;
        i_item <= {$urandom, $urandom};
    endtask

    // Mostly constants near the interesting region, some over the full range
    function automatic t_in_item random_c();
        t_in_item c;
        int       mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            c.c_re = int'($urandom_range(0, 858993459)) - 590558003;
            c.c_im = int'($urandom_range(0, 805306368)) - 402653184;
        end else if (mode < 8) begin
            c.c_re = int'($urandom_range(0, 1073741824)) - 536870912;
            c.c_im = int'($urandom_range(0, 1073741824)) - 536870912;
        end else begin
            c.c_re = $urandom;
            c.c_im = $urandom;
        end
        return c;
    endfunction

    // Compare each pixel with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel with none expected: grey %0d clipped %0b",
                         $time, o_item.grey, o_item.clipped);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_item.grey !== want.grey) begin
                    $display("%0t: grey expected %0d actual %0d",
                             $time, want.grey, o_item.grey);
                    mismatches++;
                end
                if (o_item.clipped !== want.clipped) begin
                    $display("%0t: clipped expected %0b actual %0b",
                             $time, want.clipped, o_item.clipped);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        t_pixel_case row;
        t_in_item    c;
        logic [7:0]  lim;
        logic [7:0]  gb;
        int          p, k;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, registers rewritten only where a row changes them
        for (k = 0; k < N_DIR; k++) begin
            row = dir_cases[k];
            if (row.lim != lim_now || row.gn != gain_now) begin
                set_limits(row.lim, {4'($urandom_range(0, 15)), row.gn});
            end
            issue_pixel(row.cr, row.ci, row.typed, row.want);
        end

        // Random phases; the last one runs with no idle gaps
        for (p = 0; p < N_PHASES; p++) begin
            lim = (phase_lim[p] < 0) ? 8'($urandom_range(3, 24)) : 8'(phase_lim[p]);
            gb  = (phase_gain[p] < 0) ? 8'($urandom_range(0, 255))
                                      : {4'($urandom_range(0, 15)), 4'(phase_gain[p])};
            set_limits(lim, gb);
            for (k = 0; k < phase_len[p]; k++) begin
                if (p < N_PHASES - 1 && $urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 1) == 1) begin
                        while (busy) @(negedge i_clk);
                    end
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                end
                c = random_c();
                issue_pixel(c.c_re, c.c_im, 1'b0, '0);
            end
        end

        // Drain and let any stray result show up
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Hard stop on a hang
    initial begin
        #20000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
